// File: sv/smr_pkg.sv
// Shared types, constants and the micro-op table for the stereo input mix router.
// No dependencies; every other file of the block imports this package.
package smr_pkg;

  localparam int SMOOTH_SHIFT = 10;
  localparam int SMP_W = 24;
  localparam int GAIN_W = 16;
  localparam int SIDE_W = 15;
  localparam int ROUTE_W = 3;
  localparam int LAG_W = 32;
  localparam int OP_W = 32;
  localparam int COEF_W = 17;
  localparam int FRAC_W = 14;
  localparam int PROD_W = OP_W + COEF_W;
  localparam int P_W = PROD_W - FRAC_W;
  localparam int SUM_W = P_W + 1;
  localparam int NUM_LAGS = 8;
  localparam int NUM_OPS = 11;
  localparam int CNT_W = 5;
  localparam int OPIX_W = CNT_W - 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(2 * NUM_OPS - 1);
  localparam logic [CNT_W-1:0] LAST_LAG = CNT_W'(NUM_LAGS - 1);

  localparam int ROUTE_MIX = 0;
  localparam int ROUTE_SEND = 1;
  localparam int ROUTE_KEY = 2;

  localparam logic [GAIN_W-1:0] RST_INPUT_GAIN = 16'd16384;
  localparam logic [GAIN_W-1:0] RST_MASTER_GAIN = 16'd12288;
  localparam logic [GAIN_W-1:0] RST_RETURN_GAIN = 16'd16384;
  localparam logic [LAG_W-1:0] UNITY_LAG = 32'h4000_0000;
  localparam logic [LAG_W-1:0] RST_MASTER_LAG = 32'h3000_0000;

  typedef enum logic [2:0] {
    CFG_INPUT,
    CFG_MASTER,
    CFG_RETURN,
    CFG_MIX,
    CFG_SEND,
    CFG_SIDE,
    CFG_ROUTE
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  input_gain;
    logic [GAIN_W-1:0]  master_gain;
    logic [GAIN_W-1:0]  return_gain;
    logic [GAIN_W-1:0]  mix_gain;
    logic [GAIN_W-1:0]  send_gain;
    logic [SIDE_W-1:0]  side_gain;
    logic [ROUTE_W-1:0] route_enables;
  } cfg_t;

  typedef enum logic [2:0] {
    LG_IN,
    LG_MST,
    LG_RET,
    LG_MIX,
    LG_SND,
    LG_SIDE,
    LG_MEN,
    LG_KEN
  } lag_idx_t;

  typedef enum logic [2:0] {
    A_IN,
    A_IL,
    A_T,
    A_RET,
    A_MAIN
  } a_sel_t;

  typedef enum logic [2:0] {
    ADD_ZERO,
    ADD_BUS,
    ADD_MAIN,
    ADD_TSEND,
    ADD_TKEY,
    ADD_TSIDE
  } add_sel_t;

  typedef enum logic [2:0] {
    D_IL,
    D_T,
    D_MAIN,
    D_OMAIN,
    D_OSEND,
    D_OKEY,
    D_OSIDE
  } dest_t;

  typedef struct packed {
    a_sel_t   a_sel;
    lag_idx_t c_idx;
    logic     c_inv;
    add_sel_t add_sel;
    dest_t    dest;
    logic     gate;
  } uop_t;

  typedef struct packed {
    logic vld;
    logic ch;
    uop_t op;
  } issue_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] in_l;
    logic signed [SMP_W-1:0] in_r;
    logic signed [SMP_W-1:0] bus_l;
    logic signed [SMP_W-1:0] bus_r;
    logic signed [SMP_W-1:0] ret_l;
    logic signed [SMP_W-1:0] ret_r;
    logic signed [SMP_W-1:0] tsend_l;
    logic signed [SMP_W-1:0] tsend_r;
    logic signed [SMP_W-1:0] tkey_l;
    logic signed [SMP_W-1:0] tkey_r;
    logic signed [SMP_W-1:0] tside_l;
    logic signed [SMP_W-1:0] tside_r;
  } frame_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] main_l;
    logic signed [SMP_W-1:0] main_r;
    logic signed [SMP_W-1:0] send_l;
    logic signed [SMP_W-1:0] send_r;
    logic signed [SMP_W-1:0] key_l;
    logic signed [SMP_W-1:0] key_r;
    logic signed [SMP_W-1:0] side_l;
    logic signed [SMP_W-1:0] side_r;
  } frame_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAG,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // One channel's program. Each entry is floor(a * coef / 2^14) plus an addend.
  function automatic uop_t uop_rom(input logic [OPIX_W-1:0] idx);
    uop_t u;
    u = '{a_sel: A_IN, c_idx: LG_IN, c_inv: 1'b0, add_sel: ADD_ZERO,
          dest: D_IL, gate: 1'b0};
    case (idx)
      4'd0: u = '{A_IN, LG_IN, 1'b0, ADD_ZERO, D_IL, 1'b0};
      4'd1: u = '{A_IL, LG_MIX, 1'b0, ADD_ZERO, D_T, 1'b0};
      4'd2: u = '{A_T, LG_SIDE, 1'b1, ADD_ZERO, D_T, 1'b0};
      4'd3: u = '{A_T, LG_MEN, 1'b0, ADD_BUS, D_MAIN, 1'b0};
      4'd4: u = '{A_RET, LG_RET, 1'b0, ADD_MAIN, D_MAIN, 1'b0};
      4'd5: u = '{A_MAIN, LG_MST, 1'b0, ADD_ZERO, D_OMAIN, 1'b0};
      4'd6: u = '{A_IL, LG_SND, 1'b0, ADD_ZERO, D_T, 1'b0};
      4'd7: u = '{A_T, LG_MIX, 1'b0, ADD_ZERO, D_T, 1'b0};
      4'd8: u = '{A_T, LG_MEN, 1'b0, ADD_TSEND, D_OSEND, 1'b1};
      4'd9: u = '{A_IL, LG_KEN, 1'b0, ADD_TKEY, D_OKEY, 1'b0};
      4'd10: u = '{A_IL, LG_SIDE, 1'b0, ADD_TSIDE, D_OSIDE, 1'b0};
      default: u = '{A_IN, LG_IN, 1'b0, ADD_ZERO, D_IL, 1'b0};
    endcase
    return u;
  endfunction

endpackage

// File: sv/smr_lag_bank.sv
// Bank of eight one-pole gain lags with a single shared update adder.
// Depends on smr_pkg for the configuration struct and lag indexes.
module smr_lag_bank (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smr_pkg::cfg_t                       cfg,
  input  smr_pkg::lag_idx_t                   idx,
  input  logic                                upd,
  input  logic                                inv,
  output logic signed [smr_pkg::COEF_W-1:0]   coef
);
  import smr_pkg::*;

  logic [LAG_W-1:0] lag_r [NUM_LAGS];
  logic [LAG_W-1:0] lag_cur;
  logic [LAG_W-1:0] tgt;
  logic signed [LAG_W:0] diff;
  logic signed [LAG_W:0] step;
  logic signed [LAG_W:0] sum;
  logic [LAG_W-1:0] lag_nxt;
  logic [GAIN_W-1:0] top;

  function automatic logic [LAG_W-1:0] lag_rst(input int i);
    logic [LAG_W-1:0] v;
    v = '0;
    if (i == int'(LG_IN) || i == int'(LG_RET)) begin
      v = UNITY_LAG;
    end else if (i == int'(LG_MST)) begin
      v = RST_MASTER_LAG;
    end
    return v;
  endfunction

  assign lag_cur = lag_r[idx];

  always_comb begin
    unique case (idx)
      LG_IN:   tgt = {cfg.input_gain, 16'd0};
      LG_MST:  tgt = {cfg.master_gain, 16'd0};
      LG_RET:  tgt = {cfg.return_gain, 16'd0};
      LG_MIX:  tgt = {cfg.mix_gain, 16'd0};
      LG_SND:  tgt = {cfg.send_gain, 16'd0};
      LG_SIDE: tgt = {1'b0, cfg.side_gain, 16'd0};
      LG_MEN:  tgt = cfg.route_enables[ROUTE_MIX] ? UNITY_LAG : '0;
      LG_KEN:  tgt = cfg.route_enables[ROUTE_KEY] ? UNITY_LAG : '0;
      default: tgt = '0;
    endcase
  end

  // The arithmetic shift floors the step, as the smoothing law requires.
  always_comb begin
    diff = $signed({1'b0, tgt}) - $signed({1'b0, lag_cur});
    step = diff >>> SMOOTH_SHIFT;
    sum = $signed({1'b0, lag_cur}) + step;
    lag_nxt = sum[LAG_W-1:0];
  end

  assign top = lag_cur[LAG_W-1:LAG_W-GAIN_W];
  assign coef = inv ? ($signed(COEF_W'(16384)) - $signed({1'b0, top}))
                    : $signed({1'b0, top});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LAGS; i++) begin
        lag_r[i] <= lag_rst(i);
      end
    end else if (upd) begin
      lag_r[idx] <= lag_nxt;
    end
  end

endmodule

// File: sv/smr_datapath.sv
// Shared multiply unit with a writeback stage for add and saturation.
// Holds the frame samples, per-channel temporaries and results; uses smr_pkg.
module smr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  smr_pkg::frame_in_t                 smp,
  input  smr_pkg::issue_t                    iss,
  input  logic signed [smr_pkg::COEF_W-1:0]  coef,
  input  logic                               send_en,
  output smr_pkg::frame_out_t                res
);
  import smr_pkg::*;

  frame_in_t smp_r;
  frame_out_t res_r, res_nxt;
  logic signed [OP_W-1:0] il_r [2];
  logic signed [OP_W-1:0] t_r [2];
  logic signed [OP_W-1:0] main_r [2];
  logic signed [OP_W-1:0] il_nxt [2];
  logic signed [OP_W-1:0] t_nxt [2];
  logic signed [OP_W-1:0] main_nxt [2];
  logic signed [P_W-1:0] p_r, p_nxt;
  issue_t wb_r, wb_nxt;

  logic signed [OP_W-1:0] a_op;
  logic signed [PROD_W-1:0] prod;
  logic signed [OP_W-1:0] addend;
  logic signed [P_W-1:0] p_g;
  logic signed [SUM_W-1:0] sum;
  logic signed [SMP_W-1:0] sat;

  function automatic logic signed [OP_W-1:0] sx(input logic signed [SMP_W-1:0] v);
    return {{(OP_W-SMP_W){v[SMP_W-1]}}, v};
  endfunction

  // Issue: pick the operand and multiply by the lag coefficient.
  always_comb begin
    case (iss.op.a_sel)
      A_IN:    a_op = sx(iss.ch ? smp_r.in_r : smp_r.in_l);
      A_IL:    a_op = il_r[iss.ch];
      A_T:     a_op = t_r[iss.ch];
      A_RET:   a_op = sx(iss.ch ? smp_r.ret_r : smp_r.ret_l);
      A_MAIN:  a_op = main_r[iss.ch];
      default: a_op = '0;
    endcase
    prod = a_op * coef;
    p_nxt = $signed(prod[PROD_W-1:FRAC_W]);
    wb_nxt = iss;
  end

  // Writeback: add the product to its addend, then store or saturate.
  always_comb begin
    case (wb_r.op.add_sel)
      ADD_BUS:   addend = sx(wb_r.ch ? smp_r.bus_r : smp_r.bus_l);
      ADD_MAIN:  addend = main_r[wb_r.ch];
      ADD_TSEND: addend = sx(wb_r.ch ? smp_r.tsend_r : smp_r.tsend_l);
      ADD_TKEY:  addend = sx(wb_r.ch ? smp_r.tkey_r : smp_r.tkey_l);
      ADD_TSIDE: addend = sx(wb_r.ch ? smp_r.tside_r : smp_r.tside_l);
      default:   addend = '0;
    endcase
    p_g = (wb_r.op.gate && !send_en) ? '0 : p_r;
    sum = SUM_W'(addend) + SUM_W'(p_g);
    if (sum[SUM_W-1:SMP_W-1] == '0 || sum[SUM_W-1:SMP_W-1] == '1) begin
      sat = sum[SMP_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SMP_W-1){1'b1}}};
    end

    il_nxt = il_r;
    t_nxt = t_r;
    main_nxt = main_r;
    res_nxt = res_r;
    if (wb_r.vld) begin
      unique case (wb_r.op.dest)
        D_IL:    il_nxt[wb_r.ch] = sum[OP_W-1:0];
        D_T:     t_nxt[wb_r.ch] = sum[OP_W-1:0];
        D_MAIN:  main_nxt[wb_r.ch] = sum[OP_W-1:0];
        D_OMAIN: begin
          if (wb_r.ch) res_nxt.main_r = sat;
          else res_nxt.main_l = sat;
        end
        D_OSEND: begin
          if (wb_r.ch) res_nxt.send_r = sat;
          else res_nxt.send_l = sat;
        end
        D_OKEY: begin
          if (wb_r.ch) res_nxt.key_r = sat;
          else res_nxt.key_l = sat;
        end
        D_OSIDE: begin
          if (wb_r.ch) res_nxt.side_r = sat;
          else res_nxt.side_l = sat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r.vld <= 1'b0;
    end else begin
      wb_r.vld <= wb_nxt.vld;
    end
    wb_r.ch <= wb_nxt.ch;
    wb_r.op <= wb_nxt.op;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      smp_r <= smp;
    end
    p_r <= p_nxt;
    il_r <= il_nxt;
    t_r <= t_nxt;
    main_r <= main_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// File: sv/stereo_input_mix_router_unit.sv
// Stereo input mix router: one stereo frame per transaction, eight smoothed gains.
// Each frame steps the eight lags of the lag bank, then issues eleven micro-ops per channel
// to the single shared multiplier, left and right alternating, then drains and hands off.
// A new frame is taken only in the idle state, once the last result has been handed off.
// Reset (synchronous, active low) restores default gains and lags and empties the output.
// Depends on smr_pkg, smr_lag_bank and smr_datapath.
module stereo_input_mix_router_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [smr_pkg::GAIN_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [smr_pkg::SMP_W-1:0] in_left,
  input  logic signed [smr_pkg::SMP_W-1:0] in_right,
  input  logic signed [smr_pkg::SMP_W-1:0] in_bus_left,
  input  logic signed [smr_pkg::SMP_W-1:0] in_bus_right,
  input  logic signed [smr_pkg::SMP_W-1:0] in_ret_left,
  input  logic signed [smr_pkg::SMP_W-1:0] in_ret_right,
  input  logic signed [smr_pkg::SMP_W-1:0] in_tsend_left,
  input  logic signed [smr_pkg::SMP_W-1:0] in_tsend_right,
  input  logic signed [smr_pkg::SMP_W-1:0] in_tkey_left,
  input  logic signed [smr_pkg::SMP_W-1:0] in_tkey_right,
  input  logic signed [smr_pkg::SMP_W-1:0] in_tside_left,
  input  logic signed [smr_pkg::SMP_W-1:0] in_tside_right,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [smr_pkg::SMP_W-1:0] out_main_left,
  output logic signed [smr_pkg::SMP_W-1:0] out_main_right,
  output logic signed [smr_pkg::SMP_W-1:0] out_sendout_left,
  output logic signed [smr_pkg::SMP_W-1:0] out_sendout_right,
  output logic signed [smr_pkg::SMP_W-1:0] out_keyout_left,
  output logic signed [smr_pkg::SMP_W-1:0] out_keyout_right,
  output logic signed [smr_pkg::SMP_W-1:0] out_sideout_left,
  output logic signed [smr_pkg::SMP_W-1:0] out_sideout_right
);
  import smr_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  frame_out_t out_r, out_nxt;
  cfg_t cfg_r, cfg_nxt;

  frame_in_t smp;
  frame_out_t res;
  issue_t iss;
  lag_idx_t lag_sel;
  logic lag_upd;
  logic load;
  logic signed [COEF_W-1:0] coef;

  assign smp = '{in_l: in_left, in_r: in_right, bus_l: in_bus_left, bus_r: in_bus_right,
                 ret_l: in_ret_left, ret_r: in_ret_right,
                 tsend_l: in_tsend_left, tsend_r: in_tsend_right,
                 tkey_l: in_tkey_left, tkey_r: in_tkey_right,
                 tside_l: in_tside_left, tside_r: in_tside_right};

  // Configuration decode; bits above a register's width are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INPUT:  cfg_nxt.input_gain = cfg_wdata;
        CFG_MASTER: cfg_nxt.master_gain = cfg_wdata;
        CFG_RETURN: cfg_nxt.return_gain = cfg_wdata;
        CFG_MIX:    cfg_nxt.mix_gain = cfg_wdata;
        CFG_SEND:   cfg_nxt.send_gain = cfg_wdata;
        CFG_SIDE:   cfg_nxt.side_gain = cfg_wdata[SIDE_W-1:0];
        CFG_ROUTE:  cfg_nxt.route_enables = cfg_wdata[ROUTE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load = 1'b0;
    lag_upd = 1'b0;
    iss.vld = 1'b0;
    iss.ch = cnt_r[0];
    iss.op = uop_rom(cnt_r[CNT_W-1:1]);
    lag_sel = iss.op.c_idx;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          load = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_LAG;
        end
      end
      ST_LAG: begin
        lag_upd = 1'b1;
        lag_sel = lag_idx_t'(cnt_r[2:0]);
        if (cnt_r == LAST_LAG) begin
          cnt_nxt = '0;
          state_nxt = ST_RUN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RUN: begin
        // Left and right alternate so each writeback lands before its channel reissues.
        iss.vld = 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt = res;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      cfg_r <= '{input_gain: RST_INPUT_GAIN, master_gain: RST_MASTER_GAIN,
                 return_gain: RST_RETURN_GAIN, mix_gain: '0, send_gain: '0,
                 side_gain: '0, route_enables: '0};
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  smr_lag_bank u_lag (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .idx   (lag_sel),
    .upd   (lag_upd),
    .inv   (iss.vld && iss.op.c_inv),
    .coef  (coef)
  );

  smr_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .smp     (smp),
    .iss     (iss),
    .coef    (coef),
    .send_en (cfg_r.route_enables[ROUTE_SEND]),
    .res     (res)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_main_left = out_r.main_l;
  assign out_main_right = out_r.main_r;
  assign out_sendout_left = out_r.send_l;
  assign out_sendout_right = out_r.send_r;
  assign out_keyout_left = out_r.key_l;
  assign out_keyout_right = out_r.key_r;
  assign out_sideout_left = out_r.side_l;
  assign out_sideout_right = out_r.side_r;

endmodule

// File: sim/mix_router_checker.sv
`timescale 1ns / 1ps
// Checker for the stereo input mix router: watches the register port and both channels,
// predicts every result frame from its own copy of the gains and lags, and compares them.
// Depends on smr_pkg for the frame types, widths and register indexes.
module mix_router_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [smr_pkg::GAIN_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  smr_pkg::frame_in_t         frame,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  smr_pkg::frame_out_t        result,
  output int                         fail_count,
  output int                         pending
);
  import smr_pkg::*;

  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;
  localparam longint Q14_ONE = 64'sd1 << FRAC_W;

  logic [GAIN_W-1:0]  input_gain_q, master_gain_q, return_gain_q, mix_gain_q, send_gain_q;
  logic [SIDE_W-1:0]  side_gain_q;
  logic [ROUTE_W-1:0] route_q;
  logic [LAG_W-1:0]   lags [NUM_LAGS];

  frame_out_t expected_frames [$];
  frame_out_t predicted;
  frame_out_t oldest;
  int errors;

  // One smoothing step; the step toward the target is floored.
  function automatic logic [LAG_W-1:0] lag_toward(input logic [LAG_W-1:0] lag,
                                                  input logic [LAG_W-1:0] target);
    longint diff;
    diff = longint'({32'd0, target}) - longint'({32'd0, lag});
    return LAG_W'(longint'({32'd0, lag}) + (diff >>> SMOOTH_SHIFT));
  endfunction

  function automatic longint coef_of(input logic [LAG_W-1:0] lag);
    return longint'({48'd0, lag[LAG_W-1:16]});
  endfunction

  function automatic longint q14_mul(input longint x, input longint c);
    return (x * c) >>> FRAC_W;
  endfunction

  function automatic logic signed [SMP_W-1:0] clip(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX[SMP_W-1:0];
    if (v < SAMPLE_MIN) return SAMPLE_MIN[SMP_W-1:0];
    return v[SMP_W-1:0];
  endfunction

  task automatic mix_frame(input frame_in_t f, output frame_out_t r);
    longint c_in, c_mix, c_side, c_ret, c_mst, c_snd, c_men, c_ken, c_inv;
    longint il, ir, tl, tr, main_l, main_r, snd_l, snd_r;
    lags[LG_MIX]  = lag_toward(lags[LG_MIX], {mix_gain_q, 16'd0});
    lags[LG_SND]  = lag_toward(lags[LG_SND], {send_gain_q, 16'd0});
    lags[LG_SIDE] = lag_toward(lags[LG_SIDE], {1'b0, side_gain_q, 16'd0});
    lags[LG_RET]  = lag_toward(lags[LG_RET], {return_gain_q, 16'd0});
    lags[LG_IN]   = lag_toward(lags[LG_IN], {input_gain_q, 16'd0});
    lags[LG_KEN]  = lag_toward(lags[LG_KEN], route_q[ROUTE_KEY] ? UNITY_LAG : '0);
    lags[LG_MEN]  = lag_toward(lags[LG_MEN], route_q[ROUTE_MIX] ? UNITY_LAG : '0);
    lags[LG_MST]  = lag_toward(lags[LG_MST], {master_gain_q, 16'd0});

    c_in   = coef_of(lags[LG_IN]);
    c_mix  = coef_of(lags[LG_MIX]);
    c_side = coef_of(lags[LG_SIDE]);
    c_ret  = coef_of(lags[LG_RET]);
    c_mst  = coef_of(lags[LG_MST]);
    c_snd  = coef_of(lags[LG_SND]);
    c_men  = coef_of(lags[LG_MEN]);
    c_ken  = coef_of(lags[LG_KEN]);
    // Goes negative once the side gain passes unity.
    c_inv  = Q14_ONE - c_side;

    il = q14_mul(longint'(f.in_l), c_in);
    ir = q14_mul(longint'(f.in_r), c_in);

    tl = q14_mul(q14_mul(q14_mul(il, c_mix), c_inv), c_men);
    tr = q14_mul(q14_mul(q14_mul(ir, c_mix), c_inv), c_men);
    main_l = q14_mul(longint'(f.bus_l) + tl + q14_mul(longint'(f.ret_l), c_ret), c_mst);
    main_r = q14_mul(longint'(f.bus_r) + tr + q14_mul(longint'(f.ret_r), c_ret), c_mst);

    snd_l = longint'(f.tsend_l);
    snd_r = longint'(f.tsend_r);
    if (route_q[ROUTE_SEND]) begin
      snd_l += q14_mul(q14_mul(q14_mul(il, c_snd), c_mix), c_men);
      snd_r += q14_mul(q14_mul(q14_mul(ir, c_snd), c_mix), c_men);
    end

    r.main_l = clip(main_l);
    r.main_r = clip(main_r);
    r.send_l = clip(snd_l);
    r.send_r = clip(snd_r);
    r.key_l  = clip(longint'(f.tkey_l) + q14_mul(il, c_ken));
    r.key_r  = clip(longint'(f.tkey_r) + q14_mul(ir, c_ken));
    r.side_l = clip(longint'(f.tside_l) + q14_mul(il, c_side));
    r.side_r = clip(longint'(f.tside_r) + q14_mul(ir, c_side));
  endtask

  task automatic check_field(input string name, input logic signed [SMP_W-1:0] want,
                             input logic signed [SMP_W-1:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      input_gain_q  = RST_INPUT_GAIN;
      master_gain_q = RST_MASTER_GAIN;
      return_gain_q = RST_RETURN_GAIN;
      mix_gain_q    = '0;
      send_gain_q   = '0;
      side_gain_q   = '0;
      route_q       = '0;
      lags[LG_IN]   = UNITY_LAG;
      lags[LG_MST]  = RST_MASTER_LAG;
      lags[LG_RET]  = UNITY_LAG;
      lags[LG_MIX]  = '0;
      lags[LG_SND]  = '0;
      lags[LG_SIDE] = '0;
      lags[LG_MEN]  = '0;
      lags[LG_KEN]  = '0;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUT:  input_gain_q = cfg_wdata;
          CFG_MASTER: master_gain_q = cfg_wdata;
          CFG_RETURN: return_gain_q = cfg_wdata;
          CFG_MIX:    mix_gain_q = cfg_wdata;
          CFG_SEND:   send_gain_q = cfg_wdata;
          CFG_SIDE:   side_gain_q = cfg_wdata[SIDE_W-1:0];
          CFG_ROUTE:  route_q = cfg_wdata[ROUTE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        mix_frame(frame, predicted);
        expected_frames.insert(expected_frames.size(), predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          errors++;
          $error("result transaction with no frame outstanding");
        end else begin
          oldest = expected_frames.pop_front();
          check_field("main_left", oldest.main_l, result.main_l);
          check_field("main_right", oldest.main_r, result.main_r);
          check_field("sendout_left", oldest.send_l, result.send_l);
          check_field("sendout_right", oldest.send_r, result.send_r);
          check_field("keyout_left", oldest.key_l, result.key_l);
          check_field("keyout_right", oldest.key_r, result.key_r);
          check_field("sideout_left", oldest.side_l, result.side_l);
          check_field("sideout_right", oldest.side_r, result.side_r);
        end
      end
    end
    fail_count <= errors;
    pending <= expected_frames.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the mix router testbench: clock, reset, register programming and frame stimulus,
// with random idling on both channels. Depends on smr_pkg, the router and mix_router_checker.
module testbench;
  import smr_pkg::*;

  localparam int IDLE_PCT = 13;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_FRAMES = 255;
  localparam int QUIET_PHASE = 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic signed [SMP_W-1:0] SMP_MAX = 24'h7F_FFFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 24'h80_0000;
  localparam logic signed [SMP_W-1:0] SMP_NEG_ONE = 24'hFF_FFFF;
  localparam logic [GAIN_W-1:0] GAIN_TOP = 16'd32768;
  localparam logic [GAIN_W-1:0] SIDE_TOP = 16'd16384;
  localparam logic [GAIN_W-1:0] ALL_ONES = 16'hFFFF;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [GAIN_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  frame_in_t stim;
  logic out_valid;
  logic out_ready;
  logic signed [SMP_W-1:0] res_main_l, res_main_r, res_send_l, res_send_r;
  logic signed [SMP_W-1:0] res_key_l, res_key_r, res_side_l, res_side_r;
  frame_out_t dut_result;
  int fail_count;
  int pending;
  int stall_cycles;
  logic no_idle;

  assign dut_result = {res_main_l, res_main_r, res_send_l, res_send_r,
                       res_key_l, res_key_r, res_side_l, res_side_r};

  stereo_input_mix_router_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_left           (stim.in_l),
    .in_right          (stim.in_r),
    .in_bus_left       (stim.bus_l),
    .in_bus_right      (stim.bus_r),
    .in_ret_left       (stim.ret_l),
    .in_ret_right      (stim.ret_r),
    .in_tsend_left     (stim.tsend_l),
    .in_tsend_right    (stim.tsend_r),
    .in_tkey_left      (stim.tkey_l),
    .in_tkey_right     (stim.tkey_r),
    .in_tside_left     (stim.tside_l),
    .in_tside_right    (stim.tside_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_main_left     (res_main_l),
    .out_main_right    (res_main_r),
    .out_sendout_left  (res_send_l),
    .out_sendout_right (res_send_r),
    .out_keyout_left   (res_key_l),
    .out_keyout_right  (res_key_r),
    .out_sideout_left  (res_side_l),
    .out_sideout_right (res_side_r)
  );

  mix_router_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame      (stim),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (dut_result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [SMP_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return SMP_MAX;
    if (roll < 12) return SMP_MIN;
    if (roll < 16) return '0;
    if (roll < 19) return SMP_NEG_ONE;
    if (roll < 30) return SMP_W'(int'($urandom_range(8191)) - 4096);
    return SMP_W'($urandom);
  endfunction

  function automatic frame_in_t pair_frame(input logic signed [SMP_W-1:0] l,
                                           input logic signed [SMP_W-1:0] r);
    frame_in_t f;
    f.in_l = l;    f.in_r = r;
    f.bus_l = l;   f.bus_r = r;
    f.ret_l = l;   f.ret_r = r;
    f.tsend_l = l; f.tsend_r = r;
    f.tkey_l = l;  f.tkey_r = r;
    f.tside_l = l; f.tside_r = r;
    return f;
  endfunction

  function automatic frame_in_t random_frame();
    frame_in_t f;
    f.in_l = pick_sample();    f.in_r = pick_sample();
    f.bus_l = pick_sample();   f.bus_r = pick_sample();
    f.ret_l = pick_sample();   f.ret_r = pick_sample();
    f.tsend_l = pick_sample(); f.tsend_r = pick_sample();
    f.tkey_l = pick_sample();  f.tkey_r = pick_sample();
    f.tside_l = pick_sample(); f.tside_r = pick_sample();
    return f;
  endfunction

  // Mostly in range, with the ends and out-of-range values well represented.
  function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] top);
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 30) return top;
    if (roll < 40) return ALL_ONES;
    return GAIN_W'($urandom_range(top));
  endfunction

  task automatic push_frame(input frame_in_t f);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    stim = f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [GAIN_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_all(input logic [GAIN_W-1:0] in_g, mst_g, ret_g, mix_g, snd_g,
                             side_g, route);
    write_reg(CFG_INPUT, in_g);
    write_reg(CFG_MASTER, mst_g);
    write_reg(CFG_RETURN, ret_g);
    write_reg(CFG_MIX, mix_g);
    write_reg(CFG_SEND, snd_g);
    write_reg(CFG_SIDE, side_g);
    write_reg(CFG_ROUTE, route);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    stim = '0;
    no_idle = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset gains, field extremes.
    push_frame(pair_frame(SMP_MAX, SMP_MAX));
    push_frame(pair_frame(SMP_MIN, SMP_MIN));
    push_frame(pair_frame('0, '0));
    push_frame(pair_frame(SMP_NEG_ONE, SMP_NEG_ONE));
    push_frame(pair_frame(SMP_MAX, SMP_MIN));

    // Every register at all ones: gains above range, side and route masked on write,
    // and a write to an index with no register behind it.
    settle();
    program_all(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    write_reg(CFG_UNUSED, 16'h1234);
    push_frame(pair_frame(SMP_MAX, SMP_MAX));
    push_frame(pair_frame(SMP_MIN, SMP_MIN));
    push_frame(pair_frame(SMP_MIN, SMP_MAX));
    push_frame(pair_frame(SMP_MAX, SMP_MIN));
    push_frame(pair_frame('0, '0));
    repeat (3) push_frame(random_frame());

    // Nominal tops with the send path turned off.
    settle();
    program_all(GAIN_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP, SIDE_TOP,
                GAIN_W'((1 << ROUTE_MIX) | (1 << ROUTE_KEY)));
    push_frame(pair_frame(SMP_MAX, SMP_MIN));
    repeat (3) push_frame(random_frame());

    // Send only, with side gain past unity so the mix share inverts.
    settle();
    write_reg(CFG_ROUTE, GAIN_W'(1 << ROUTE_SEND));
    write_reg(CFG_SIDE, 16'h7FFF);
    push_frame(pair_frame(SMP_MAX, SMP_MAX));
    repeat (2) push_frame(random_frame());

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: program_all('0, '0, '0, '0, '0, '0, '0);
        1: program_all(GAIN_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP, SIDE_TOP,
                       GAIN_W'((1 << ROUTE_W) - 1));
        default: program_all(pick_gain(GAIN_TOP), pick_gain(GAIN_TOP), pick_gain(GAIN_TOP),
                             pick_gain(GAIN_TOP), pick_gain(GAIN_TOP), pick_gain(SIDE_TOP),
                             GAIN_W'($urandom_range((1 << ROUTE_W) - 1)));
      endcase
      no_idle = (phase == QUIET_PHASE);
      for (int i = 0; i < PHASE_FRAMES; i++) push_frame(random_frame());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
sv/smr_pkg.sv
sv/smr_lag_bank.sv
sv/smr_datapath.sv
sv/stereo_input_mix_router_unit.sv
sim/mix_router_checker.sv
sim/testbench.sv
